FILE: sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg : shared types and constants of the pure pursuit steering block
// Transaction types, register indexes, sequencer codes, CORDIC angle table
// and the exact squaring function used by the distance tests.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int PATH_DEPTH   = 1024;
   localparam int COORD_WIDTH  = 32;
   localparam int ADDR_W       = $clog2(PATH_DEPTH);
   localparam int CNT_W        = $clog2(PATH_DEPTH + 1);
   localparam int CFG_W        = 31;
   // magnitude of a coordinate difference or of a radius
   localparam int MAG_W        = (COORD_WIDTH + 1 > CFG_W) ? COORD_WIDTH + 1 : CFG_W;
   localparam int LO_W         = MAG_W - 1;
   localparam int SQ_W         = 2 * MAG_W;
   localparam int CORD_W       = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 4;
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W       = 5;
   localparam int K_Q30        = 652032874;
   localparam int NUM_W        = 62;
   localparam int DEN_W        = CFG_W + 13;
   localparam int DIV_CNT_W    = $clog2(NUM_W);

   localparam logic [31:0] BAM_HALF    = 32'h8000_0000;
   localparam logic [31:0] BAM_QUARTER = 32'h4000_0000;

   localparam logic [1:0] CSR_LOOKAHEAD = 2'd0;
   localparam logic [1:0] CSR_CRUISE    = 2'd1;
   localparam logic [1:0] CSR_GOAL_TOL  = 2'd2;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_STEP   = 2'd2
   } action_type;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] linear_velocity;
      logic signed [31:0] angular_velocity;
      logic               goal_reached;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_CLEAR, OP_APPEND, OP_RADII, OP_SQUARE, OP_RR_SAVE,
      OP_RD_LAST, OP_RD_IDX, OP_DIFF, OP_IDX_INC, OP_QPROD, OP_QSUM,
      OP_YAW_START, OP_YAW_SAVE, OP_BEAR_START, OP_ERR, OP_SIN_START,
      OP_MUL, OP_DIV_START, OP_RESULT, OP_GOAL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic idx_last;
      logic ge_tol;
      logic ge_look;
      logic cordic_busy;
      logic div_busy;
      logic rsp_busy;
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RADII, ST_RSQ, ST_RSAVE, ST_LRD, ST_LDIFF, ST_LSQ, ST_LCMP,
      ST_SRD, ST_SDIFF, ST_SSQ, ST_SCMP, ST_QPROD, ST_QSUM, ST_YSTART,
      ST_YWAIT, ST_BSTART, ST_BWAIT, ST_SSTART, ST_SWAIT, ST_MUL, ST_DSTART,
      ST_DWAIT, ST_FIN, ST_GOAL
   } state_type;

   // atan(2^-i) as a binary angle, 2^32 = 2*pi
   function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000028;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000002;
         5'd29: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // exact square with one LO_W x LO_W product; top bit handled by shifts
   function automatic logic [SQ_W-1:0] square(input logic [MAG_W-1:0] m);
      logic [LO_W-1:0]   lo;
      logic [2*LO_W-1:0] p;
      logic [SQ_W-1:0]   r;
      lo = m[LO_W-1:0];
      p  = lo * lo;
      r  = SQ_W'(p);
      if (m[MAG_W-1]) begin
         r = r + (SQ_W'(lo) << MAG_W) + (SQ_W'(1) << (2 * LO_W));
      end
      return r;
   endfunction

endpackage

FILE: sv/pps_cordic.sv
// ----------------------------------------------------------------------------
// pps_cordic : iterative CORDIC unit
// One micro-rotation per cycle over 30 steps, vectoring (atan2) or
// rotation (sine) mode. Start values are prepared by the datapath.
// ----------------------------------------------------------------------------
module pps_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              rotate,
   input  logic signed [pps_pkg::CORD_W-1:0] x_init,
   input  logic signed [pps_pkg::CORD_W-1:0] y_init,
   input  logic [31:0]                       z_init,
   output logic                              busy,
   output logic signed [pps_pkg::CORD_W-1:0] y_out,
   output logic [31:0]                       z_out
);

   logic signed [pps_pkg::CORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]                       z_ff, z_in, a;
   logic [pps_pkg::STEP_W-1:0]        step_ff;
   logic                              busy_ff, mode_ff;
   logic signed [pps_pkg::CORD_W-1:0] sx, sy;

   always_comb begin
      sx = x_ff >>> step_ff;
      sy = y_ff >>> step_ff;
      a  = pps_pkg::atan_bam(step_ff);
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (mode_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - sy; y_in = y_ff + sx; z_in = z_ff - a;
         end else begin
            x_in = x_ff + sy; y_in = y_ff - sx; z_in = z_ff + a;
         end
      end else if (y_ff > 0) begin
         x_in = x_ff + sy; y_in = y_ff - sx; z_in = z_ff + a;
      end else if (y_ff < 0) begin
         x_in = x_ff - sy; y_in = y_ff + sx; z_in = z_ff - a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == pps_pkg::STEP_W'(pps_pkg::CORDIC_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= x_init;
         y_ff    <= y_init;
         z_ff    <= z_init;
         mode_ff <= rotate;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign busy  = busy_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

FILE: sv/pps_div.sv
// ----------------------------------------------------------------------------
// pps_div : restoring divider
// Unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module pps_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pps_pkg::NUM_W-1:0]   numer,
   input  logic [pps_pkg::DEN_W-1:0]   denom,
   output logic                        busy,
   output logic [pps_pkg::NUM_W-1:0]   quot
);

   logic [pps_pkg::DEN_W-1:0]     rem_ff, rem_in, den_ff;
   logic [pps_pkg::NUM_W-1:0]     quo_ff, quo_in;
   logic [pps_pkg::DEN_W:0]       trial;
   logic [pps_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff, ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[pps_pkg::NUM_W-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? pps_pkg::DEN_W'(trial - {1'b0, den_ff})
                  : pps_pkg::DEN_W'(trial);
      quo_in = {quo_ff[pps_pkg::NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == pps_pkg::DIV_CNT_W'(pps_pkg::NUM_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= numer;
         den_ff <= denom;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy = busy_ff;
   assign quot = quo_ff;

endmodule

FILE: sv/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath : path store, distance tests, yaw, steering arithmetic
// Executes one sequencer command per cycle and reports status back.
// ----------------------------------------------------------------------------
module pps_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pps_pkg::cmd_type    cmd,
   output pps_pkg::status_type status,
   input  pps_pkg::req_type    req_payload,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pps_pkg::rsp_type    rsp_payload
);

   localparam int CW = pps_pkg::COORD_WIDTH;
   localparam int W  = pps_pkg::CORD_W;

   logic [pps_pkg::CFG_W-1:0]   look_ff, cruise_ff, tol_ff, lnz;
   logic [pps_pkg::CNT_W-1:0]   count_ff;
   logic [pps_pkg::ADDR_W-1:0]  idx_ff, last_addr, rd_addr;
   logic signed [CW-1:0]        x_mem [pps_pkg::PATH_DEPTH];
   logic signed [CW-1:0]        y_mem [pps_pkg::PATH_DEPTH];
   logic signed [CW-1:0]        rd_x_ff, rd_y_ff, px, py;
   pps_pkg::req_type            req_ff;
   logic signed [CW:0]          dxw, dyw;
   logic [CW:0]                 magx, magy;
   logic signed [W-1:0]         dx_ff, dy_ff, n_ff, d_ff;
   logic [pps_pkg::MAG_W-1:0]   mag_a_ff, mag_b_ff;
   logic [pps_pkg::SQ_W-1:0]    prod_a_ff, prod_b_ff, rr_look_ff, rr_tol_ff;
   logic [pps_pkg::SQ_W:0]      dist_sum;
   logic signed [31:0]          p_xx, p_yy, p_zz, p_ww, p_xy, p_wz, p_xz, p_wy;
   logic signed [33:0]          g, g_abs, sumsq, nq, dq;
   logic [31:0]                 yaw_ff, err_ff, z_fold;
   logic signed [31:0]          e;
   logic                        s_neg_ff;
   logic [pps_pkg::NUM_W-1:0]   m_ff, quot, qsat;
   logic signed [W-1:0]         s_clamp;
   logic [pps_pkg::CFG_W-1:0]   s_mag;
   logic [31:0]                 ang;
   logic                        rsp_valid_ff;
   pps_pkg::rsp_type            rsp_ff;
   // cordic hookup
   logic                        cor_start, cor_rotate, cor_busy;
   logic signed [W-1:0]         cor_x, cor_y, vx, vy, cor_yo;
   logic [31:0]                 cor_z, cor_zo;
   logic                        div_start, div_busy;

   assign px        = req_ff.point_x[CW-1:0];
   assign py        = req_ff.point_y[CW-1:0];
   assign last_addr = pps_pkg::ADDR_W'(count_ff - pps_pkg::CNT_W'(1));
   assign rd_addr   = (cmd.op == pps_pkg::OP_RD_LAST) ? last_addr : idx_ff;
   assign lnz       = (look_ff == '0) ? pps_pkg::CFG_W'(1) : look_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff   <= pps_pkg::CFG_W'(65536);
         cruise_ff <= pps_pkg::CFG_W'(32768);
         tol_ff    <= pps_pkg::CFG_W'(6554);
      end else if (csr_valid) begin
         unique case (csr_index)
            pps_pkg::CSR_LOOKAHEAD: look_ff   <= csr_data[pps_pkg::CFG_W-1:0];
            pps_pkg::CSR_CRUISE:    cruise_ff <= csr_data[pps_pkg::CFG_W-1:0];
            pps_pkg::CSR_GOAL_TOL:  tol_ff    <= csr_data[pps_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // path store
   always_ff @(posedge clock) begin
      if (cmd.op == pps_pkg::OP_APPEND
          && count_ff < pps_pkg::CNT_W'(pps_pkg::PATH_DEPTH)) begin
         x_mem[count_ff[pps_pkg::ADDR_W-1:0]] <= req_payload.point_x[CW-1:0];
         y_mem[count_ff[pps_pkg::ADDR_W-1:0]] <= req_payload.point_y[CW-1:0];
      end
      if (cmd.op == pps_pkg::OP_RD_LAST || cmd.op == pps_pkg::OP_RD_IDX) begin
         rd_x_ff <= x_mem[rd_addr];
         rd_y_ff <= y_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.op == pps_pkg::OP_CLEAR) begin
         count_ff <= '0;
      end else if (cmd.op == pps_pkg::OP_APPEND
                   && count_ff < pps_pkg::CNT_W'(pps_pkg::PATH_DEPTH)) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_comb begin
      dxw  = {rd_x_ff[CW-1], rd_x_ff} - {px[CW-1], px};
      dyw  = {rd_y_ff[CW-1], rd_y_ff} - {py[CW-1], py};
      magx = dxw[CW] ? (CW+1)'(-dxw) : (CW+1)'(dxw);
      magy = dyw[CW] ? (CW+1)'(-dyw) : (CW+1)'(dyw);
      dist_sum = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};
   end

   // quaternion terms
   always_comb begin
      g     = (34'(p_xz) - 34'(p_wy)) <<< 1;
      g_abs = g[33] ? -g : g;
      sumsq = 34'(p_xx) + 34'(p_yy) + 34'(p_zz) + 34'(p_ww);
      nq    = (34'(p_xy) + 34'(p_wz)) <<< 1;
      dq    = 34'(p_ww) + 34'(p_xx) - 34'(p_yy) - 34'(p_zz);
   end

   // sine folding, clamp and saturation
   always_comb begin
      e      = err_ff;
      z_fold = (e > 32'sh4000_0000 || e < 32'shC000_0000)
               ? (pps_pkg::BAM_HALF - err_ff) : err_ff;
      s_clamp = cor_yo;
      if (cor_yo > W'(signed'({1'b0, pps_pkg::BAM_QUARTER}))) begin
         s_clamp = W'(signed'({1'b0, pps_pkg::BAM_QUARTER}));
      end else if (cor_yo < -W'(signed'({1'b0, pps_pkg::BAM_QUARTER}))) begin
         s_clamp = -W'(signed'({1'b0, pps_pkg::BAM_QUARTER}));
      end
      s_mag = s_clamp[W-1] ? pps_pkg::CFG_W'(-s_clamp) : pps_pkg::CFG_W'(s_clamp);
      if (!s_neg_ff) begin
         qsat = (quot > pps_pkg::NUM_W'(32'h7FFF_FFFF))
                ? pps_pkg::NUM_W'(32'h7FFF_FFFF) : quot;
         ang  = qsat[31:0];
      end else begin
         qsat = (quot > pps_pkg::NUM_W'(pps_pkg::BAM_HALF))
                ? pps_pkg::NUM_W'(pps_pkg::BAM_HALF) : quot;
         ang  = 32'd0 - qsat[31:0];
      end
   end

   // CORDIC start values; vectoring pre-rotates by pi when x is negative
   always_comb begin
      cor_start  = 1'b0;
      cor_rotate = 1'b0;
      vx = (cmd.op == pps_pkg::OP_YAW_START) ? d_ff : dx_ff;
      vy = (cmd.op == pps_pkg::OP_YAW_START) ? n_ff : dy_ff;
      cor_x = vx;
      cor_y = vy;
      cor_z = 32'd0;
      if (vx < 0) begin
         cor_x = -vx;
         cor_y = -vy;
         cor_z = pps_pkg::BAM_HALF;
      end
      if (cmd.op == pps_pkg::OP_YAW_START || cmd.op == pps_pkg::OP_BEAR_START) begin
         cor_start = 1'b1;
      end else if (cmd.op == pps_pkg::OP_SIN_START) begin
         cor_start  = 1'b1;
         cor_rotate = 1'b1;
         cor_x      = W'(pps_pkg::K_Q30);
         cor_y      = '0;
         cor_z      = z_fold;
      end
   end

   assign div_start = (cmd.op == pps_pkg::OP_DIV_START);

   pps_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cor_start),
      .rotate (cor_rotate),
      .x_init (cor_x),
      .y_init (cor_y),
      .z_init (cor_z),
      .busy   (cor_busy),
      .y_out  (cor_yo),
      .z_out  (cor_zo)
   );

   pps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (m_ff + pps_pkg::NUM_W'({lnz, 12'b0})),
      .denom ({lnz, 13'b0}),
      .busy  (div_busy),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.op == pps_pkg::OP_RADII) begin
         idx_ff <= '0;
      end else if (cmd.op == pps_pkg::OP_IDX_INC) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         pps_pkg::OP_LATCH:    req_ff <= req_payload;
         pps_pkg::OP_RADII: begin
            mag_a_ff <= pps_pkg::MAG_W'(look_ff);
            mag_b_ff <= pps_pkg::MAG_W'(tol_ff);
         end
         pps_pkg::OP_SQUARE: begin
            prod_a_ff <= pps_pkg::square(mag_a_ff);
            prod_b_ff <= pps_pkg::square(mag_b_ff);
         end
         pps_pkg::OP_RR_SAVE: begin
            rr_look_ff <= prod_a_ff;
            rr_tol_ff  <= prod_b_ff;
         end
         pps_pkg::OP_DIFF: begin
            dx_ff    <= W'(dxw);
            dy_ff    <= W'(dyw);
            mag_a_ff <= pps_pkg::MAG_W'(magx);
            mag_b_ff <= pps_pkg::MAG_W'(magy);
         end
         pps_pkg::OP_QPROD: begin
            p_xx <= req_ff.quat_x * req_ff.quat_x;
            p_yy <= req_ff.quat_y * req_ff.quat_y;
            p_zz <= req_ff.quat_z * req_ff.quat_z;
            p_ww <= req_ff.quat_w * req_ff.quat_w;
            p_xy <= req_ff.quat_x * req_ff.quat_y;
            p_wz <= req_ff.quat_w * req_ff.quat_z;
            p_xz <= req_ff.quat_x * req_ff.quat_z;
            p_wy <= req_ff.quat_w * req_ff.quat_y;
         end
         pps_pkg::OP_QSUM: begin
            // gimbal lock: atan2(0,0) gives a yaw of zero
            if (g_abs >= sumsq) begin
               n_ff <= '0;
               d_ff <= '0;
            end else begin
               n_ff <= W'(nq);
               d_ff <= W'(dq);
            end
         end
         pps_pkg::OP_YAW_SAVE: yaw_ff <= cor_zo;
         pps_pkg::OP_ERR:      err_ff <= cor_zo - yaw_ff;
         pps_pkg::OP_MUL: begin
            s_neg_ff <= s_clamp[W-1];
            m_ff     <= s_mag * cruise_ff;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == pps_pkg::OP_RESULT || cmd.op == pps_pkg::OP_GOAL) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == pps_pkg::OP_RESULT) begin
         rsp_ff.linear_velocity  <= {1'b0, cruise_ff};
         rsp_ff.angular_velocity <= ang;
         rsp_ff.goal_reached     <= 1'b0;
      end else if (cmd.op == pps_pkg::OP_GOAL) begin
         rsp_ff.linear_velocity  <= '0;
         rsp_ff.angular_velocity <= '0;
         rsp_ff.goal_reached     <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      status.count_zero  = (count_ff == '0);
      status.idx_last    = (idx_ff == last_addr);
      status.ge_tol      = dist_sum >= {1'b0, rr_tol_ff};
      status.ge_look     = dist_sum >= {1'b0, rr_look_ff};
      status.cordic_busy = cor_busy;
      status.div_busy    = div_busy;
      status.rsp_busy    = rsp_valid_ff;
   end

endmodule

FILE: sv/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl : control step sequencer
// Walks the radius squares, goal check, path scan, yaw, bearing, sine,
// product and division, issuing at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module pps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  pps_pkg::action_type  req_action,
   output logic                 req_ready,
   input  pps_pkg::status_type  status,
   output pps_pkg::cmd_type     cmd
);

   pps_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.op    = pps_pkg::OP_NONE;
      unique case (state_ff)
         pps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_action)
                  pps_pkg::ACT_CLEAR:  cmd.op = pps_pkg::OP_CLEAR;
                  pps_pkg::ACT_APPEND: cmd.op = pps_pkg::OP_APPEND;
                  pps_pkg::ACT_STEP: begin
                     cmd.op = pps_pkg::OP_LATCH;
                     if (!status.count_zero) begin
                        state_in = pps_pkg::ST_RADII;
                     end
                  end
                  default: ;
               endcase
            end
         end
         pps_pkg::ST_RADII: begin
            cmd.op = pps_pkg::OP_RADII; state_in = pps_pkg::ST_RSQ;
         end
         pps_pkg::ST_RSQ: begin
            cmd.op = pps_pkg::OP_SQUARE; state_in = pps_pkg::ST_RSAVE;
         end
         pps_pkg::ST_RSAVE: begin
            cmd.op = pps_pkg::OP_RR_SAVE; state_in = pps_pkg::ST_LRD;
         end
         pps_pkg::ST_LRD: begin
            cmd.op = pps_pkg::OP_RD_LAST; state_in = pps_pkg::ST_LDIFF;
         end
         pps_pkg::ST_LDIFF: begin
            cmd.op = pps_pkg::OP_DIFF; state_in = pps_pkg::ST_LSQ;
         end
         pps_pkg::ST_LSQ: begin
            cmd.op = pps_pkg::OP_SQUARE; state_in = pps_pkg::ST_LCMP;
         end
         pps_pkg::ST_LCMP: begin
            state_in = status.ge_tol ? pps_pkg::ST_SRD : pps_pkg::ST_GOAL;
         end
         pps_pkg::ST_SRD: begin
            cmd.op = pps_pkg::OP_RD_IDX; state_in = pps_pkg::ST_SDIFF;
         end
         pps_pkg::ST_SDIFF: begin
            cmd.op = pps_pkg::OP_DIFF; state_in = pps_pkg::ST_SSQ;
         end
         pps_pkg::ST_SSQ: begin
            cmd.op = pps_pkg::OP_SQUARE; state_in = pps_pkg::ST_SCMP;
         end
         pps_pkg::ST_SCMP: begin
            // first hit or the last waypoint: its differences stay in place
            if (status.ge_look || status.idx_last) begin
               state_in = pps_pkg::ST_QPROD;
            end else begin
               cmd.op   = pps_pkg::OP_IDX_INC;
               state_in = pps_pkg::ST_SRD;
            end
         end
         pps_pkg::ST_QPROD: begin
            cmd.op = pps_pkg::OP_QPROD; state_in = pps_pkg::ST_QSUM;
         end
         pps_pkg::ST_QSUM: begin
            cmd.op = pps_pkg::OP_QSUM; state_in = pps_pkg::ST_YSTART;
         end
         pps_pkg::ST_YSTART: begin
            cmd.op = pps_pkg::OP_YAW_START; state_in = pps_pkg::ST_YWAIT;
         end
         pps_pkg::ST_YWAIT: begin
            if (!status.cordic_busy) begin
               cmd.op = pps_pkg::OP_YAW_SAVE; state_in = pps_pkg::ST_BSTART;
            end
         end
         pps_pkg::ST_BSTART: begin
            cmd.op = pps_pkg::OP_BEAR_START; state_in = pps_pkg::ST_BWAIT;
         end
         pps_pkg::ST_BWAIT: begin
            if (!status.cordic_busy) begin
               cmd.op = pps_pkg::OP_ERR; state_in = pps_pkg::ST_SSTART;
            end
         end
         pps_pkg::ST_SSTART: begin
            cmd.op = pps_pkg::OP_SIN_START; state_in = pps_pkg::ST_SWAIT;
         end
         pps_pkg::ST_SWAIT: begin
            if (!status.cordic_busy) begin
               state_in = pps_pkg::ST_MUL;
            end
         end
         pps_pkg::ST_MUL: begin
            cmd.op = pps_pkg::OP_MUL; state_in = pps_pkg::ST_DSTART;
         end
         pps_pkg::ST_DSTART: begin
            cmd.op = pps_pkg::OP_DIV_START; state_in = pps_pkg::ST_DWAIT;
         end
         pps_pkg::ST_DWAIT: begin
            if (!status.div_busy) begin
               state_in = pps_pkg::ST_FIN;
            end
         end
         pps_pkg::ST_FIN: begin
            if (!status.rsp_busy) begin
               cmd.op = pps_pkg::OP_RESULT; state_in = pps_pkg::ST_IDLE;
            end
         end
         pps_pkg::ST_GOAL: begin
            if (!status.rsp_busy) begin
               cmd.op = pps_pkg::OP_GOAL; state_in = pps_pkg::ST_IDLE;
            end
         end
         default: state_in = pps_pkg::ST_IDLE;
      endcase
   end

endmodule

FILE: sv/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering : pure pursuit path tracker, top level
// Path store, lookahead search and steering command generation.
// ----------------------------------------------------------------------------
// Clear and append transactions are handled in the idle state, which the
// sequencer does not leave for them. In a control step that does not end
// at the goal, each waypoint up to the chosen one goes through a read,
// difference, squaring and compare on the single read port of the path
// store; then come two 30-step CORDIC runs (yaw and bearing), a 30-step
// CORDIC sine and a bit-serial divider with a 62-bit quotient. A step on an
// empty path is taken and gives no result; a result waits in an output
// register while the next transaction is accepted. Configuration writes are always taken.
module pure_pursuit_steering (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pps_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pps_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);

   pps_pkg::cmd_type    cmd;
   pps_pkg::status_type status;

   assign csr_ready = 1'b1;

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_payload.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   pps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/sv/pps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pps_checker : steering command predictor and scoreboard
// Watches the request, response and register channels of the pure pursuit
// block, keeps its own path and register copies, predicts each command and
// compares every response field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pps_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pps_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pps_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data,
   output int               fail_count,
   output int               pending
);

   logic signed [63:0] path_x [pps_pkg::PATH_DEPTH];
   logic signed [63:0] path_y [pps_pkg::PATH_DEPTH];
   int unsigned        path_len;
   logic [30:0]        lookahead, cruise, goal_tol;
   pps_pkg::rsp_type   cmd_queue [$];

   function automatic logic [31:0] atan_step(input int i);
      logic [31:0] t [30];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
            32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
            32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};
      return t[i];
   endfunction

   // dx^2 + dy^2 >= r^2, exact
   function automatic bit reach_ge(input logic signed [63:0] dx,
                                   input logic signed [63:0] dy,
                                   input logic [30:0] r);
      logic [129:0] s;
      logic [129:0] ax, ay;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      s  = ax * ax + ay * ay;
      return s >= 130'(r) * 130'(r);
   endfunction

   function automatic logic [31:0] bam_atan2(input logic signed [63:0] y0,
                                             input logic signed [63:0] x0);
      logic signed [63:0] x, y, nx, ny;
      logic [31:0]        z;
      x = x0; y = y0; z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = pps_pkg::BAM_HALF;
      end
      for (int i = 0; i < 30; i++) begin
         nx = x; ny = y;
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_step(i);
         end else if (y < 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_step(i);
         end
         x = nx; y = ny;
      end
      return z;
   endfunction

   function automatic logic signed [63:0] sine_q30(input logic [31:0] a0);
      logic signed [63:0] x, y, z, nx, ny, e;
      logic [31:0]        a;
      a = a0;
      e = 64'($signed(a));
      if (e > 64'sh4000_0000 || e < -64'sh4000_0000) a = pps_pkg::BAM_HALF - a;
      z = 64'($signed(a));
      x = pps_pkg::K_Q30; y = 0;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_step(i);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_step(i);
         end
         x = nx; y = ny;
      end
      if (y > 64'sh4000_0000) y = 64'sh4000_0000;
      if (y < -64'sh4000_0000) y = -64'sh4000_0000;
      return y;
   endfunction

   function automatic logic [31:0] quat_heading(input pps_pkg::req_type r);
      logic signed [63:0] qx, qy, qz, qw, g, d;
      qx = r.quat_x; qy = r.quat_y; qz = r.quat_z; qw = r.quat_w;
      g = 2 * (qx * qz - qw * qy);
      d = qx * qx + qy * qy + qz * qz + qw * qw;
      if (((g < 0) ? -g : g) >= d) return 0;
      return bam_atan2(2 * (qx * qy + qw * qz), qw * qw + qx * qx - qy * qy - qz * qz);
   endfunction

   function automatic pps_pkg::rsp_type steer_command(input pps_pkg::req_type r);
      pps_pkg::rsp_type   c;
      int unsigned        pick, last;
      logic signed [63:0] px, py, s;
      logic [31:0]        err;
      logic [95:0]        m, dv, q;
      px = r.point_x; py = r.point_y;
      last = path_len - 1;
      pick = last;
      for (int k = 0; k < path_len; k++) begin
         if (reach_ge(path_x[k] - px, path_y[k] - py, lookahead)) begin
            pick = k;
            break;
         end
      end
      c = '0;
      if (!reach_ge(path_x[last] - px, path_y[last] - py, goal_tol)) begin
         c.goal_reached = 1'b1;
         return c;
      end
      err = bam_atan2(path_y[pick] - py, path_x[pick] - px) - quat_heading(r);
      s   = sine_q30(err);
      m   = 96'((s < 0) ? -s : s) * 96'(cruise);
      dv  = 96'((lookahead == 0) ? 31'd1 : lookahead) << 13;
      q   = (m + dv / 2) / dv;
      if (s >= 0) c.angular_velocity = (q > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      else c.angular_velocity = (q > 96'h8000_0000) ? 32'h8000_0000 : -q[31:0];
      c.linear_velocity = {1'b0, cruise};
      return c;
   endfunction

   assign pending = cmd_queue.size();

   always @(posedge clock) begin
      pps_pkg::rsp_type want;
      if (reset) begin
         path_len   <= 0;
         lookahead  <= 31'd65536;
         cruise     <= 31'd32768;
         goal_tol   <= 31'd6554;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pps_pkg::CSR_LOOKAHEAD: lookahead <= csr_data[30:0];
               pps_pkg::CSR_CRUISE:    cruise    <= csr_data[30:0];
               pps_pkg::CSR_GOAL_TOL:  goal_tol  <= csr_data[30:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_payload.action)
               pps_pkg::ACT_CLEAR: path_len <= 0;
               pps_pkg::ACT_APPEND: begin
                  if (path_len < pps_pkg::PATH_DEPTH) begin
                     path_x[path_len] <= 64'(req_payload.point_x);
                     path_y[path_len] <= 64'(req_payload.point_y);
                     path_len         <= path_len + 1;
                  end
               end
               pps_pkg::ACT_STEP:
                  if (path_len != 0) cmd_queue.push_back(steer_command(req_payload));
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (cmd_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %p", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = cmd_queue.pop_front();
               if (want !== rsp_payload) begin
                  if (fail_count < 10)
                     $display("mismatch: exp lin %0d ang %0d goal %0d, got lin %0d ang %0d goal %0d",
                              want.linear_velocity, want.angular_velocity, want.goal_reached,
                              rsp_payload.linear_velocity, rsp_payload.angular_velocity,
                              rsp_payload.goal_reached);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: tb/sv/pure_pursuit_steering_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pure_pursuit_steering_tb : top level testbench of the steering block
// Builds paths, sends control steps with bursty timing and a stalling
// receiver, sweeps the registers between phases and reports the verdict.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_tb;

   logic             clock, reset;
   logic             req_valid, req_ready, rsp_valid, rsp_ready;
   logic             csr_valid, csr_ready;
   logic [1:0]       csr_index;
   logic [31:0]      csr_data;
   pps_pkg::req_type req_payload;
   pps_pkg::rsp_type rsp_payload;
   int               fail_count, pending;
   int               burst_left;

   pure_pursuit_steering dut (.*);

   pps_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("tb: failure");
      $finish;
   end

   // receiver stall pattern: long open stretches, then choppy stretches
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) < 2) repeat ($urandom_range(1, 40)) begin
            rsp_ready <= $urandom_range(0, 3) == 0;
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send(input pps_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic pps_pkg::req_type mk(input pps_pkg::action_type a,
                                           input logic [31:0] x,
                                           input logic [31:0] y);
      pps_pkg::req_type r;
      r.action  = a;
      r.point_x = x;
      r.point_y = y;
      r.quat_x  = 16'($urandom); r.quat_y = 16'($urandom);
      r.quat_z  = 16'($urandom); r.quat_w = 16'($urandom);
      return r;
   endfunction

   // planar quaternion rotation with small x and y jitter in most steps, else all four random
   function automatic pps_pkg::req_type mk_step(input logic [31:0] x,
                                                input logic [31:0] y);
      pps_pkg::req_type r;
      r = mk(pps_pkg::ACT_STEP, x, y);
      if ($urandom_range(0, 3) != 0) begin
         r.quat_x = 16'($urandom_range(0, 400) - 200);
         r.quat_y = 16'($urandom_range(0, 400) - 200);
      end
      return r;
   endfunction

   task automatic settle;
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [31:0] near(input int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   initial begin
      pps_pkg::req_type r;
      logic [31:0] bx, by;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = pps_pkg::CSR_LOOKAHEAD;
      csr_data    = '0;
      burst_left  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty path, unused action, extremes, gimbal lock, goal
      send(mk_step(0, 0));
      r = mk(pps_pkg::ACT_APPEND, 0, 0); r.action = pps_pkg::action_type'(2'd3); send(r);
      send(mk_step(0, 0));
      send(mk(pps_pkg::ACT_APPEND, 32'h7FFF_FFFF, 32'h8000_0000));
      send(mk(pps_pkg::ACT_APPEND, 32'h8000_0000, 32'h7FFF_FFFF));
      send(mk(pps_pkg::ACT_APPEND, 0, 0));
      r = mk_step(32'h8000_0000, 32'h8000_0000); send(r);
      r = mk_step(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      r.quat_x = 16'h7FFF; r.quat_y = 16'h8000; r.quat_z = 16'h7FFF; r.quat_w = 16'h8000;
      send(r);
      r = mk_step(0, 0); r.quat_x = '0; r.quat_y = '0; r.quat_z = '0; r.quat_w = '0; send(r);
      r = mk_step(0, 0); r.quat_x = '0; r.quat_y = 16'h5A82; r.quat_z = '0; r.quat_w = 16'h5A82;
      send(r);
      r = mk_step(100, -100); r.quat_x = '0; r.quat_y = '0; r.quat_z = 16'h7FFF; r.quat_w = '0;
      send(r);
      send(mk(pps_pkg::ACT_CLEAR, 0, 0));
      send(mk_step(0, 0));
      send(mk(pps_pkg::ACT_APPEND, 32'h0001_0000, 0));
      send(mk_step(32'h0003_0000, 0));
      send(mk_step(32'h0002_0000, 0));
      settle();

      // full path: fill past the depth, appends beyond it are dropped
      write_reg(pps_pkg::CSR_LOOKAHEAD, 32'h7FFF_FFFF);
      write_reg(pps_pkg::CSR_CRUISE, 32'h7FFF_FFFF);
      write_reg(pps_pkg::CSR_GOAL_TOL, 0);
      for (int k = 0; k < pps_pkg::PATH_DEPTH + 3; k++)
         send(mk(pps_pkg::ACT_APPEND, $urandom, $urandom));
      send(mk_step(0, 0));
      send(mk_step($urandom, $urandom));
      settle();
      write_reg(2'd3, $urandom);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(pps_pkg::CSR_LOOKAHEAD, 0); write_reg(pps_pkg::CSR_CRUISE, 0);
               write_reg(pps_pkg::CSR_GOAL_TOL, 32'hFFFF_FFFF);
            end
            1: begin
               write_reg(pps_pkg::CSR_LOOKAHEAD, 1);
               write_reg(pps_pkg::CSR_CRUISE, 32'h7FFF_FFFF);
               write_reg(pps_pkg::CSR_GOAL_TOL, 0);
            end
            default: begin
               write_reg(pps_pkg::CSR_LOOKAHEAD, $urandom_range(1, 32'h0008_0000));
               write_reg(pps_pkg::CSR_CRUISE, $urandom);
               write_reg(pps_pkg::CSR_GOAL_TOL, $urandom_range(0, 32'h0001_0000));
            end
         endcase
         for (int j = 0; j < 6; j++) begin
            send(mk(pps_pkg::ACT_CLEAR, $urandom, $urandom));
            bx = near(32'h0004_0000); by = near(32'h0004_0000);
            repeat ($urandom_range(1, 8)) begin
               bx = bx + near(32'h0002_0000); by = by + near(32'h0002_0000);
               send(mk(pps_pkg::ACT_APPEND, bx, by));
            end
            repeat ($urandom_range(3, 8)) begin
               case ($urandom_range(0, 9))
                  0: send(mk(pps_pkg::ACT_APPEND, $urandom, $urandom));
                  1: send(mk_step($urandom, $urandom));
                  2: send(mk_step(bx + near(300), by + near(300)));
                  default: send(mk_step(bx + near(32'h0006_0000), by + near(32'h0006_0000)));
               endcase
            end
         end
         settle();
      end

      repeat (2000) begin
         @(posedge clock);
         if (pending == 0) break;
      end
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
sv/pps_pkg.sv
sv/pps_cordic.sv
sv/pps_div.sv
sv/pps_datapath.sv
sv/pps_ctrl.sv
sv/pure_pursuit_steering.sv
tb/sv/pps_checker.sv
tb/sv/pure_pursuit_steering_tb.sv
